[src/dexp_pkg.sv]
`timescale 1ns / 1ps

package dexp_pkg;

  localparam int TIME_BITS        = 24;
  localparam int RESULT_FRAC_BITS = 14;
  localparam int REG_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int EXP_FRAC         = 20;
  localparam int EXP_QB           = 25;
  localparam int FIFO_DEPTH       = 4;

  localparam logic [REG_W-1:0] RISE_RESET  = 16'd128;
  localparam logic [REG_W-1:0] DECAY_RESET = 16'd1280;
  localparam logic [REG_W-1:0] ONSET_RESET = 16'd0;

  // log2(e) in Q30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE  = 2'd0,
    REG_DECAY = 2'd1,
    REG_ONSET = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOGR,
    ST_LOGD,
    ST_PREP,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_POW,
    ST_SHIFT,
    ST_FIN
  } peak_state_e;

  typedef struct packed {
    logic             busy;
    logic             zero;
    logic             degen;
    logic             pk_neg;
    logic [30:0]      pmag;
    logic [REG_W-1:0] rise;
    logic [REG_W-1:0] decay;
    logic [REG_W-1:0] onset;
  } cfg_t;

  typedef logic [EXP_FRAC-1:0][29:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = x;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // successive square roots of one half, Q30
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] c;
    c      = isqrt64(64'd1 << 59);
    tab[0] = c[29:0];
    for (int i = 1; i < EXP_FRAC; i++) begin
      c      = isqrt64({c[33:0], 30'b0});
      tab[i] = c[29:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = build_roots();

endpackage

[src/dexp_if.sv]
`timescale 1ns / 1ps

interface dexp_in_if #(
  parameter int TIME_BITS = dexp_pkg::TIME_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink   (input valid, input sample_time, output ready);
endinterface

interface dexp_out_if #(
  parameter int RESULT_FRAC_BITS = dexp_pkg::RESULT_FRAC_BITS
) ();
  logic                      valid;
  logic                      ready;
  logic [RESULT_FRAC_BITS:0] conductance;

  modport source (output valid, output conductance, input ready);
  modport sink   (input valid, input conductance, output ready);
endinterface

[src/dexp_peak.sv]
`timescale 1ns / 1ps

module dexp_peak (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dexp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dexp_pkg::REG_W-1:0]     cfg_data_i,
  output dexp_pkg::cfg_t                 cfg_o
);

  localparam int FR = dexp_pkg::EXP_FRAC;
  localparam int QB = dexp_pkg::EXP_QB;

  dexp_pkg::peak_state_e state_q, state_d;

  logic [15:0] rise_q, decay_q, onset_q;
  logic [15:0] reff_q, reff_d;
  logic        zero_q, zero_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [30:0] m_q, m_d;
  logic [23:0] lr_q, lr_d, ld_q, ld_d;
  logic [23:0] lmag_q, lmag_d;
  logic [15:0] dmag_q, dmag_d;
  logic        dgp_q, dgp_d;
  logic        sel_q, sel_d;
  logic [39:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [QB-1:0] quo_q, quo_d, nlo_q, nlo_d;
  logic        ovf_q, ovf_d;
  logic [30:0] pa_q, pa_d, pb_q, pb_d;
  logic        degen_q, degen_d;
  logic        pkneg_q, pkneg_d;
  logic [30:0] pmag_q, pmag_d;

  logic [30:0] mul_b;
  logic [61:0] prod;
  logic [4:0]  ridx;

  function automatic logic [3:0] msb16(input logic [15:0] v);
    logic [3:0] k;
    k = '0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) k = 4'(i);
    end
    return k;
  endfunction

  function automatic logic [30:0] norm16(input logic [15:0] v, input logic [3:0] k);
    return 31'(v) << (5'd30 - 5'(k));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q  <= dexp_pkg::RISE_RESET;
      decay_q <= dexp_pkg::DECAY_RESET;
      onset_q <= dexp_pkg::ONSET_RESET;
    end else if (cfg_we_i) begin
      unique case (dexp_pkg::cfg_reg_e'(cfg_idx_i))
        dexp_pkg::REG_RISE:  rise_q  <= cfg_data_i;
        dexp_pkg::REG_DECAY: decay_q <= cfg_data_i;
        dexp_pkg::REG_ONSET: onset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ridx  = 5'(FR - 1) - cnt_q;
  assign mul_b = (state_q == dexp_pkg::ST_POW) ? {1'b0, dexp_pkg::ROOTS[cnt_q]} : m_q;
  assign prod  = m_q * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dexp_pkg::ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reff_q  <= reff_d;
    zero_q  <= zero_d;
    m_q     <= m_d;
    lr_q    <= lr_d;
    ld_q    <= ld_d;
    lmag_q  <= lmag_d;
    dmag_q  <= dmag_d;
    dgp_q   <= dgp_d;
    sel_q   <= sel_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    nlo_q   <= nlo_d;
    ovf_q   <= ovf_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    degen_q <= degen_d;
    pkneg_q <= pkneg_d;
    pmag_q  <= pmag_d;
  end

  always_comb begin
    logic [15:0] reff;
    logic [3:0]  k;
    logic [31:0] sq;
    logic [16:0] rr;
    logic        qb;
    logic [30:0] p;
    state_d = state_q;
    cnt_d   = cnt_q;
    reff_d  = reff_q;
    zero_d  = zero_q;
    m_d     = m_q;
    lr_d    = lr_q;
    ld_d    = ld_q;
    lmag_d  = lmag_q;
    dmag_d  = dmag_q;
    dgp_d   = dgp_q;
    sel_d   = sel_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    nlo_d   = nlo_q;
    ovf_d   = ovf_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    degen_d = degen_q;
    pkneg_d = pkneg_q;
    pmag_d  = pmag_q;
    reff    = (rise_q == decay_q) ? rise_q - 16'd1 : rise_q;
    sq      = prod[61:30];
    qb      = sq[31];
    rr      = {rem_q[15:0], nlo_q[QB-1]};
    p       = '0;
    k       = '0;
    unique case (state_q)
      dexp_pkg::ST_IDLE: ;
      dexp_pkg::ST_LOAD: begin
        k       = msb16(reff);
        reff_d  = reff;
        zero_d  = (decay_q == '0) || (reff == '0);
        m_d     = norm16(reff, k);
        lr_d    = {k, 20'b0};
        cnt_d   = '0;
        state_d = dexp_pkg::ST_LOGR;
      end
      dexp_pkg::ST_LOGR, dexp_pkg::ST_LOGD: begin
        // square the mantissa, one fraction bit per round
        m_d = qb ? sq[31:1] : sq[30:0];
        if (state_q == dexp_pkg::ST_LOGR) lr_d[19:0] = {lr_q[18:0], qb};
        else ld_d[19:0] = {ld_q[18:0], qb};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(FR - 1)) begin
          cnt_d = '0;
          if (state_q == dexp_pkg::ST_LOGR) begin
            k       = msb16(decay_q);
            m_d     = norm16(decay_q, k);
            ld_d    = {k, 20'b0};
            state_d = dexp_pkg::ST_LOGD;
          end else begin
            state_d = dexp_pkg::ST_PREP;
          end
        end
      end
      dexp_pkg::ST_PREP: begin
        if (decay_q > reff_q) begin
          dgp_d  = ld_q <= lr_q;
          lmag_d = ld_q - lr_q;
          dmag_d = decay_q - reff_q;
        end else begin
          dgp_d  = lr_q <= ld_q;
          lmag_d = lr_q - ld_q;
          dmag_d = reff_q - decay_q;
        end
        sel_d   = 1'b0;
        state_d = dexp_pkg::ST_MUL;
      end
      dexp_pkg::ST_MUL: begin
        num_d   = (sel_q ? decay_q : reff_q) * lmag_q;
        state_d = dexp_pkg::ST_DINIT;
      end
      dexp_pkg::ST_DINIT: begin
        ovf_d   = {1'b0, num_q[39:QB]} >= dmag_q;
        rem_d   = 17'(num_q[39:QB]);
        nlo_d   = num_q[QB-1:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = dexp_pkg::ST_DIV;
      end
      dexp_pkg::ST_DIV: begin
        if (rr >= {1'b0, dmag_q}) begin
          rem_d = rr - {1'b0, dmag_q};
          quo_d = {quo_q[QB-2:0], 1'b1};
        end else begin
          rem_d = rr;
          quo_d = {quo_q[QB-2:0], 1'b0};
        end
        nlo_d = nlo_q << 1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(QB - 1)) begin
          cnt_d   = '0;
          m_d     = 31'h4000_0000;
          state_d = dexp_pkg::ST_POW;
        end
      end
      dexp_pkg::ST_POW: begin
        if (quo_q[ridx]) m_d = prod[60:30];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(FR - 1)) begin
          cnt_d   = '0;
          state_d = dexp_pkg::ST_SHIFT;
        end
      end
      dexp_pkg::ST_SHIFT: begin
        p = (ovf_q || quo_q[QB-1:FR] == 5'd31) ? '0 : m_q >> quo_q[QB-1:FR];
        if (!sel_q) begin
          pa_d    = p;
          sel_d   = 1'b1;
          state_d = dexp_pkg::ST_MUL;
        end else begin
          pb_d    = p;
          state_d = dexp_pkg::ST_FIN;
        end
      end
      dexp_pkg::ST_FIN: begin
        pkneg_d = pb_q > pa_q;
        pmag_d  = (pb_q > pa_q) ? pb_q - pa_q : pa_q - pb_q;
        degen_d = dgp_q || (pb_q == pa_q);
        state_d = dexp_pkg::ST_IDLE;
      end
      default: state_d = dexp_pkg::ST_LOAD;
    endcase
    if (cfg_we_i) state_d = dexp_pkg::ST_LOAD;
  end

  assign cfg_o.busy   = state_q != dexp_pkg::ST_IDLE;
  assign cfg_o.zero   = zero_q;
  assign cfg_o.degen  = degen_q;
  assign cfg_o.pk_neg = pkneg_q;
  assign cfg_o.pmag   = pmag_q;
  assign cfg_o.rise   = reff_q;
  assign cfg_o.decay  = decay_q;
  assign cfg_o.onset  = onset_q;

endmodule

[src/dexp_front.sv]
`timescale 1ns / 1ps

module dexp_front #(
  parameter int TIME_BITS = dexp_pkg::TIME_BITS
) (
  input  dexp_pkg::cfg_t   cfg_i,
  input  logic             cfg_we_i,
  dexp_in_if.sink          sample_s,
  output logic             push_valid_o,
  output logic [TIME_BITS:0] push_data_o,
  input  logic             push_ready_i
);

  logic                 hold;
  logic [TIME_BITS-1:0] onset;
  logic                 kill;

  // no samples while the peak terms are being rebuilt
  assign hold  = cfg_i.busy || cfg_we_i;
  assign onset = TIME_BITS'(cfg_i.onset);
  assign kill  = (sample_s.sample_time < onset) || cfg_i.zero;

  assign sample_s.ready = !hold && push_ready_i;
  assign push_valid_o   = sample_s.valid && !hold;
  assign push_data_o    = {kill, sample_s.sample_time - onset};

endmodule

[src/dexp_fifo.sv]
`timescale 1ns / 1ps

module dexp_fifo #(
  parameter int W     = dexp_pkg::TIME_BITS + 1,
  parameter int DEPTH = dexp_pkg::FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  logic [W-1:0] push_data_i,
  output logic         push_ready_o,
  output logic         pop_valid_o,
  output logic [W-1:0] pop_data_o,
  input  logic         pop_ready_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      if (pop)  rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

[src/dexp_back.sv]
`timescale 1ns / 1ps

module dexp_back #(
  parameter int TIME_BITS        = dexp_pkg::TIME_BITS,
  parameter int RESULT_FRAC_BITS = dexp_pkg::RESULT_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dexp_pkg::cfg_t       cfg_i,
  input  logic                 pop_valid_i,
  input  logic [TIME_BITS:0]   pop_data_i,
  output logic                 pop_ready_o,
  dexp_out_if.source           result_m
);

  localparam int XW  = TIME_BITS + 31;
  localparam int QB  = dexp_pkg::EXP_QB;
  localparam int FR  = dexp_pkg::EXP_FRAC;
  localparam int F   = RESULT_FRAC_BITS;
  localparam int OW  = F + 1;
  localparam int ND  = F + 1;
  localparam int NST = 1 + (QB + 1) + (FR + 1) + 1 + 1 + (ND + 1);
  localparam logic [OW-1:0] OUT_MAX = OW'((3 << F) >> 1);

  logic adv;
  logic [NST-1:0] vl_q, vl_d;

  logic [XW-1:0] x_q, x_d;
  logic          k0_q, k0_d;

  // exponent dividers, lane 0 by decay, lane 1 by rise
  logic [26:0]   dr_q  [0:QB][2], dr_d  [0:QB][2];
  logic [QB-1:0] dq_q  [0:QB][2], dq_d  [0:QB][2];
  logic          dov_q [0:QB][2], dov_d [0:QB][2];
  logic [QB-1:0] dxl_q [0:QB], dxl_d [0:QB];
  logic          dk_q  [0:QB], dk_d  [0:QB];

  logic [30:0]   pm_q  [0:FR][2], pm_d  [0:FR][2];
  logic [QB-1:0] pe_q  [0:FR][2], pe_d  [0:FR][2];
  logic          pov_q [0:FR][2], pov_d [0:FR][2];
  logic          pk_q  [0:FR], pk_d  [0:FR];

  logic [30:0]   ex_q [2], ex_d [2];
  logic          ek_q, ek_d;

  logic [30:0]   rw_mag_q, rw_mag_d;
  logic          rw_nz_q, rw_nz_d;
  logic          rw_deg_q, rw_deg_d;
  logic [OW-1:0] rw_dv_q, rw_dv_d;

  logic [31:0]   nr_q   [0:ND], nr_d   [0:ND];
  logic [OW-1:0] nq_q   [0:ND], nq_d   [0:ND];
  logic [OW-1:0] nl_q   [0:ND], nl_d   [0:ND];
  logic          nsat_q [0:ND], nsat_d [0:ND];
  logic          nnz_q  [0:ND], nnz_d  [0:ND];
  logic          ndeg_q [0:ND], ndeg_d [0:ND];
  logic [OW-1:0] ndv_q  [0:ND], ndv_d  [0:ND];

  logic          out_vld_q, out_vld_d;
  logic [OW-1:0] out_dat_q, out_dat_d;
  logic [OW-1:0] val;

  assign adv         = !out_vld_q || result_m.ready;
  assign pop_ready_o = adv;

  always_comb begin
    logic [63:0] x64;
    logic [25:0] dd [2];
    logic [15:0] dl [2];
    logic [26:0] rr;
    logic [60:0] prod;
    logic [4:0]  n;
    logic [30:0] ra, rb, mag;
    logic        neg;
    logic [31:0] nrr, pm32;
    vl_d  = {vl_q[NST-2:0], pop_valid_i};
    x_d   = pop_data_i[TIME_BITS-1:0] * dexp_pkg::LOG2E_Q30;
    k0_d  = pop_data_i[TIME_BITS];
    x64   = 64'(x_q);
    dl[0] = cfg_i.decay;
    dl[1] = cfg_i.rise;
    pm32  = {1'b0, cfg_i.pmag};

    for (int l = 0; l < 2; l++) begin
      dd[l]       = {dl[l], 10'b0};
      dov_d[0][l] = x64[63:35] >= 29'(dl[l]);
      dr_d[0][l]  = {1'b0, x64[QB+25:QB]};
      dq_d[0][l]  = '0;
    end
    dxl_d[0] = x64[QB-1:0];
    dk_d[0]  = k0_q;
    for (int k = 1; k <= QB; k++) begin
      for (int l = 0; l < 2; l++) begin
        rr = {dr_q[k-1][l][25:0], dxl_q[k-1][QB-1]};
        if (rr >= {1'b0, dd[l]}) begin
          dr_d[k][l] = rr - {1'b0, dd[l]};
          dq_d[k][l] = {dq_q[k-1][l][QB-2:0], 1'b1};
        end else begin
          dr_d[k][l] = rr;
          dq_d[k][l] = {dq_q[k-1][l][QB-2:0], 1'b0};
        end
        dov_d[k][l] = dov_q[k-1][l];
      end
      dxl_d[k] = dxl_q[k-1] << 1;
      dk_d[k]  = dk_q[k-1];
    end

    // one fraction bit of the exponent per stage
    for (int l = 0; l < 2; l++) begin
      pm_d[0][l]  = 31'h4000_0000;
      pe_d[0][l]  = dq_q[QB][l];
      pov_d[0][l] = dov_q[QB][l];
    end
    pk_d[0] = dk_q[QB];
    for (int p = 1; p <= FR; p++) begin
      for (int l = 0; l < 2; l++) begin
        prod        = pm_q[p-1][l] * dexp_pkg::ROOTS[p-1];
        pm_d[p][l]  = pe_q[p-1][l][FR-p] ? prod[60:30] : pm_q[p-1][l];
        pe_d[p][l]  = pe_q[p-1][l];
        pov_d[p][l] = pov_q[p-1][l];
      end
      pk_d[p] = pk_q[p-1];
    end

    for (int l = 0; l < 2; l++) begin
      n       = pe_q[FR][l][QB-1:FR];
      ex_d[l] = (pov_q[FR][l] || n == 5'd31) ? '0 : pm_q[FR][l] >> n;
    end
    ek_d = pk_q[FR];

    ra       = ex_q[0];
    rb       = ex_q[1];
    neg      = rb > ra;
    mag      = neg ? rb - ra : ra - rb;
    rw_mag_d = mag;
    rw_deg_d = cfg_i.degen;
    rw_nz_d  = !ek_q && (mag != '0) && (cfg_i.degen ? !neg : (neg == cfg_i.pk_neg));
    rw_dv_d  = OW'(mag >> (30 - F));

    // normalizing divide, quotient limited to OW bits
    nsat_d[0] = {1'b0, rw_mag_q} >= {cfg_i.pmag, 1'b0};
    nr_d[0]   = 32'(rw_mag_q >> 1);
    nl_d[0]   = {rw_mag_q[0], {F{1'b0}}};
    nq_d[0]   = '0;
    nnz_d[0]  = rw_nz_q;
    ndeg_d[0] = rw_deg_q;
    ndv_d[0]  = rw_dv_q;
    for (int j = 1; j <= ND; j++) begin
      nrr = {nr_q[j-1][30:0], nl_q[j-1][OW-1]};
      if (nrr >= pm32) begin
        nr_d[j] = nrr - pm32;
        nq_d[j] = {nq_q[j-1][OW-2:0], 1'b1};
      end else begin
        nr_d[j] = nrr;
        nq_d[j] = {nq_q[j-1][OW-2:0], 1'b0};
      end
      nl_d[j]   = nl_q[j-1] << 1;
      nsat_d[j] = nsat_q[j-1];
      nnz_d[j]  = nnz_q[j-1];
      ndeg_d[j] = ndeg_q[j-1];
      ndv_d[j]  = ndv_q[j-1];
    end

    if (!nnz_q[ND]) val = '0;
    else if (ndeg_q[ND]) val = (ndv_q[ND] > OUT_MAX) ? OUT_MAX : ndv_q[ND];
    else if (nsat_q[ND]) val = OUT_MAX;
    else val = (nq_q[ND] > OUT_MAX) ? OUT_MAX : nq_q[ND];

    out_vld_d = adv ? vl_q[NST-1] : out_vld_q;
    out_dat_d = adv ? val : out_dat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) vl_q <= vl_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_dat_q <= out_dat_d;
    if (adv) begin
      x_q      <= x_d;
      k0_q     <= k0_d;
      dr_q     <= dr_d;
      dq_q     <= dq_d;
      dov_q    <= dov_d;
      dxl_q    <= dxl_d;
      dk_q     <= dk_d;
      pm_q     <= pm_d;
      pe_q     <= pe_d;
      pov_q    <= pov_d;
      pk_q     <= pk_d;
      ex_q     <= ex_d;
      ek_q     <= ek_d;
      rw_mag_q <= rw_mag_d;
      rw_nz_q  <= rw_nz_d;
      rw_deg_q <= rw_deg_d;
      rw_dv_q  <= rw_dv_d;
      nr_q     <= nr_d;
      nq_q     <= nq_d;
      nl_q     <= nl_d;
      nsat_q   <= nsat_d;
      nnz_q    <= nnz_d;
      ndeg_q   <= ndeg_d;
      ndv_q    <= ndv_d;
    end
  end

  assign result_m.valid       = out_vld_q;
  assign result_m.conductance = out_dat_q;

endmodule

[src/dual_exponential_synapse_waveform_core.sv]
`timescale 1ns / 1ps

// Peak-normalized dual-exponential conductance kernel. Each sample time, less the
// onset delay, gives exp(-t/decay) - exp(-t/rise) divided by its peak value, in
// unsigned Q1.RESULT_FRAC_BITS clamped to 0..1.5. The pipeline takes one sample per
// cycle and stalls as a whole while the result register is not taken; its depth is
// set by the two exponent dividers, the 20 root-multiply stages and the peak
// normalizing divide, each resolving one bit per stage. The peak terms depend only
// on the time constants and are rebuilt after reset and after every register write
// by a sequencer with a multiplier shared by its log and power steps and a
// one-bit-per-cycle divider; no sample is accepted during the rebuild.
module dual_exponential_synapse_waveform_core #(
  parameter int TIME_BITS        = dexp_pkg::TIME_BITS,
  parameter int RESULT_FRAC_BITS = dexp_pkg::RESULT_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dexp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dexp_pkg::REG_W-1:0]     cfg_data_i,
  dexp_in_if.sink                        sample_i,
  dexp_out_if.source                     result_o
);

  localparam logic [RESULT_FRAC_BITS:0] OUT_MAX =
    (RESULT_FRAC_BITS + 1)'((3 << RESULT_FRAC_BITS) >> 1);

  dexp_pkg::cfg_t       cfg;
  logic                 push_valid, push_ready;
  logic [TIME_BITS:0]   push_data;
  logic                 pop_valid, pop_ready;
  logic [TIME_BITS:0]   pop_data;

  dexp_peak u_peak (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dexp_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .cfg_i        (cfg),
    .cfg_we_i     (cfg_we_i),
    .sample_s     (sample_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  dexp_fifo #(
    .W     (TIME_BITS + 1),
    .DEPTH (dexp_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  dexp_back #(
    .TIME_BITS        (TIME_BITS),
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .result_m    (result_o)
  );

  // no sample may slip in while the peak terms are stale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |-> !cfg.busy)
    else $error("sample accepted while peak terms rebuild");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> cfg.busy)
    else $error("register write did not restart peak sequencer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.conductance <= OUT_MAX))
    else $error("conductance above saturation limit");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int PERIOD    = 12;
  localparam int LATENCY   = 53 + dexp_pkg::RESULT_FRAC_BITS + 8;
  localparam int SETTLE    = 139 + 20;
  localparam longint LIMIT = 2000000;
  localparam logic [63:0] LN2E = 64'd1549082005;
  localparam logic [63:0] OUT_MAX = (64'd3 << dexp_pkg::RESULT_FRAC_BITS) >> 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dexp_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [dexp_pkg::REG_W-1:0] cfg_data_i = '0;

  dexp_in_if  sample_if ();
  dexp_out_if result_if ();

  dual_exponential_synapse_waveform_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .sample_i  (sample_if.sink),
    .result_o  (result_if.source)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // shadow of the time constants and delay
  logic [15:0] rise_tc, decay_tc, onset;
  logic [63:0] half_roots [dexp_pkg::EXP_FRAC];
  logic [dexp_pkg::RESULT_FRAC_BITS:0] conductance_q[$];
  bit failed = 0;
  bit stim_done = 0;
  longint cycles = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] exp2_neg(input logic [63:0] e);
    logic [63:0] n, m;
    n = e >> dexp_pkg::EXP_FRAC;
    m = 64'd1 << 30;
    if (n >= 31) return 0;
    for (int i = 1; i <= dexp_pkg::EXP_FRAC; i++)
      if (e[dexp_pkg::EXP_FRAC-i]) m = (m * half_roots[i-1]) >> 30;
    return m >> n;
  endfunction

  function automatic logic [63:0] log2_fix(input logic [63:0] v);
    int k;
    logic [63:0] m, res;
    k = 15;
    while (k > 0 && !v[k]) k--;
    m = v << (30 - k);
    res = 64'(k) << dexp_pkg::EXP_FRAC;
    for (int i = 1; i <= dexp_pkg::EXP_FRAC; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        res[dexp_pkg::EXP_FRAC-i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [dexp_pkg::RESULT_FRAC_BITS:0] predict_conductance(
      input logic [dexp_pkg::TIME_BITS-1:0] s);
    logic [63:0] t, r, d, ra, rb, rmag, lr, ld, lmag, dmag, pa, pb, pmag, q;
    bit raw_neg, pk_neg, degen;
    r = rise_tc;
    d = decay_tc;
    if (s < onset) return 0;
    t = s - onset;
    if (d == 0) return 0;
    if (r == d) r = r - 1;
    if (r == 0) return 0;
    ra = exp2_neg(((t * LN2E) / d) >> 10);
    rb = exp2_neg(((t * LN2E) / r) >> 10);
    raw_neg = rb > ra;
    rmag = raw_neg ? rb - ra : ra - rb;
    if (rmag == 0) return 0;
    lr = log2_fix(r);
    ld = log2_fix(d);
    degen = 0;
    pk_neg = 0;
    if (d > r) begin
      if (ld <= lr) degen = 1;
      lmag = ld - lr;
      dmag = d - r;
    end else begin
      if (lr <= ld) degen = 1;
      lmag = lr - ld;
      dmag = r - d;
    end
    if (!degen) begin
      pa = exp2_neg((r * lmag) / dmag);
      pb = exp2_neg((d * lmag) / dmag);
      pk_neg = pb > pa;
      pmag = pk_neg ? pb - pa : pa - pb;
      if (pmag == 0) degen = 1;
    end
    if (degen) begin
      if (raw_neg) return 0;
      q = rmag >> (30 - dexp_pkg::RESULT_FRAC_BITS);
    end else begin
      if (raw_neg != pk_neg) return 0;
      q = (rmag << dexp_pkg::RESULT_FRAC_BITS) / pmag;
    end
    if (q > OUT_MAX) q = OUT_MAX;
    return q[dexp_pkg::RESULT_FRAC_BITS:0];
  endfunction

  task automatic write_reg(input dexp_pkg::cfg_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dexp_pkg::REG_RISE:  rise_tc = val;
      dexp_pkg::REG_DECAY: decay_tc = val;
      dexp_pkg::REG_ONSET: onset = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    while (conductance_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [15:0] r, input logic [15:0] d, input logic [15:0] o);
    drain();
    write_reg(dexp_pkg::REG_RISE, r);
    write_reg(dexp_pkg::REG_DECAY, d);
    write_reg(dexp_pkg::REG_ONSET, o);
  endtask

  // one sample word; golden < 0 means use the predictor
  task automatic send_sample(input logic [dexp_pkg::TIME_BITS-1:0] s, input int golden);
    logic [dexp_pkg::RESULT_FRAC_BITS:0] exp_g;
    int idle;
    idle = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
    exp_g = predict_conductance(s);
    if (golden >= 0 && exp_g != golden[dexp_pkg::RESULT_FRAC_BITS:0]) begin
      $error("table conductance expected %0d predictor %0d", golden, exp_g);
      failed = 1;
    end
    repeat (idle) begin
      @(negedge clk_i);
      sample_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    sample_if.valid       <= 1'b1;
    sample_if.sample_time <= s;
    do @(posedge clk_i); while (!sample_if.ready);
    conductance_q.push_back(exp_g);
  endtask

  typedef struct {
    logic [15:0] r, d, o;
    logic [dexp_pkg::TIME_BITS-1:0] s;
    int golden;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{16'd128, 16'd1280, 16'd0, 24'd0, 0},
    '{16'd128, 16'd1280, 16'd0, 24'hFFFFFF, 0},
    '{16'd128, 16'd1280, 16'd0, 24'd400, -1},
    '{16'd128, 16'd1280, 16'd0, 24'd1, -1},
    '{16'd128, 16'd1280, 16'd100, 24'd99, 0},
    '{16'd128, 16'd1280, 16'd100, 24'd100, 0},
    '{16'd128, 16'd1280, 16'hFFFF, 24'hFFFE, 0},
    '{16'd128, 16'd1280, 16'hFFFF, 24'hFFFFFF, -1},
    '{16'd500, 16'd500, 16'd0, 24'd500, -1},
    '{16'd1, 16'd1, 16'd0, 24'd5, 0},
    '{16'd0, 16'd1280, 16'd0, 24'd300, 0},
    '{16'd128, 16'd0, 16'd0, 24'd300, 0},
    '{16'd2000, 16'd100, 16'd0, 24'd300, -1},
    '{16'hFFFF, 16'hFFFE, 16'd0, 24'd70000, -1},
    '{16'd1, 16'hFFFF, 16'd0, 24'd7, -1},
    '{16'hFFFF, 16'd1, 16'd0, 24'd7, -1},
    '{16'd3, 16'd4, 16'd0, 24'd4, -1},
    '{16'hFFFF, 16'hFFFF, 16'h5555, 24'hAAAAAA, -1},
    '{16'd256, 16'd2560, 16'd0, 24'h800000, -1}
  };

  initial begin
    logic [dexp_pkg::TIME_BITS-1:0] s;
    logic [15:0] r, d, o;
    rise_tc = dexp_pkg::RISE_RESET;
    decay_tc = dexp_pkg::DECAY_RESET;
    onset = dexp_pkg::ONSET_RESET;
    for (int i = 0; i < dexp_pkg::EXP_FRAC; i++)
      half_roots[i] = (i == 0) ? int_sqrt(64'd1 << 59) : int_sqrt(half_roots[i-1] << 30);
    sample_if.valid = 1'b0;
    sample_if.sample_time = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].r != rise_tc || dir_rows[i].d != decay_tc || dir_rows[i].o != onset)
        set_timing(dir_rows[i].r, dir_rows[i].d, dir_rows[i].o);
      send_sample(dir_rows[i].s, dir_rows[i].golden);
    end

    for (int ph = 0; ph < 15; ph++) begin
      r = (ph % 5 == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
      d = (ph % 5 == 1) ? 16'($urandom) : 16'($urandom_range(1, 12000));
      if (ph == 7) d = r;
      o = (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 500));
      set_timing(r, d, o);
      for (int k = 0; k < 130; k++) begin
        case ($urandom_range(0, 3))
          0: s = dexp_pkg::TIME_BITS'($urandom);
          1: s = dexp_pkg::TIME_BITS'(o)
                 + dexp_pkg::TIME_BITS'($urandom_range(0, 64 * (32'(d) + 1)));
          default: s = dexp_pkg::TIME_BITS'(o)
                       + dexp_pkg::TIME_BITS'($urandom_range(0, 8 * (32'(d) + 1)));
        endcase
        send_sample(s, -1);
      end
    end

    drain();
    stim_done = 1;
  end

  // sink side with random stalls
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_if.ready <= ($urandom_range(0, 2) == 0) ? 1'b1 : ($urandom_range(0, 6) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (conductance_q.size() == 0) begin
        $error("conductance word with none expected: %0d", result_if.conductance);
        failed = 1;
      end else begin
        logic [dexp_pkg::RESULT_FRAC_BITS:0] want;
        want = conductance_q.pop_front();
        if (result_if.conductance !== want) begin
          $error("conductance expected %0d actual %0d", want, result_if.conductance);
          failed = 1;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (stim_done) begin
        if (!failed && conductance_q.size() == 0)
          $display("[ OK ] regression clean");
        else
          $display("[FAIL] regression broken");
        $finish;
      end else if (cycles > LIMIT + SETTLE) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end
endmodule
